@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AFE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define AFE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define AFE_ASSERT_SAME(lbl, ante, cons)
`define AFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/afe_pkg.sv @@
`timescale 1ns / 1ps
package afe_pkg;

   localparam int QUO_W = 8;
   localparam int LEN_W = 32;
   localparam int DT_W = 24;
   localparam int REM_W = LEN_W + QUO_W;
   localparam int DIV_W = LEN_W + QUO_W - 1;
   localparam int CNT_W = 3;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [LEN_W-1:0] LEN_MIN_US = 32'd10000;
   localparam logic [LEN_W-1:0] LEN_DEFAULT_US = 32'd1000000;
   localparam logic [QUO_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [QUO_W-1:0] ALPHA_CLEAR = 8'd0;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_IN     = 3'd1,
      KIND_OUT    = 3'd2,
      KIND_IN_OUT = 3'd3,
      KIND_OUT_IN = 3'd4
   } fade_kind_type;

   typedef enum logic {
      REG_FADE_KIND   = 1'b0,
      REG_FADE_LENGTH = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NUMER,
      ST_SCALE,
      ST_DIVIDE,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic latch_req;
      logic exec;
      logic numer;
      logic scale;
      logic div_step;
      logic commit;
   } afe_cmd_type;

   typedef struct packed {
      logic tick_active;
   } afe_status_type;

endpackage

@@ rtl/afe_req_if.sv @@
`timescale 1ns / 1ps
interface afe_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [afe_pkg::DT_W-1:0]  elapsed_us;

   modport source (output valid, output mode, output elapsed_us, input ready);
   modport sink (input valid, input mode, input elapsed_us, output ready);
endinterface

@@ rtl/afe_rsp_if.sv @@
`timescale 1ns / 1ps
interface afe_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [afe_pkg::QUO_W-1:0]  alpha;
   logic                       fading;
   logic                       finished;

   modport source (output valid, output alpha, output fading, output finished, input ready);
   modport sink (input valid, input alpha, input fading, input finished, output ready);
endinterface

@@ rtl/afe_csr.sv @@
`timescale 1ns / 1ps
module afe_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [afe_pkg::ADDR_W-1:0]  paddr,
   input  logic [afe_pkg::DATA_W-1:0]  pwdata,
   output logic [afe_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output logic [2:0]                  cfg_kind,
   output logic [afe_pkg::LEN_W-1:0]   cfg_len
);

   logic [2:0]                 kind_ff, kind_in;
   logic [afe_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       wr_en;
   afe_pkg::reg_idx_type       idx;

   // Registers are word aligned; the low address bits are ignored.
   assign idx = afe_pkg::reg_idx_type'(paddr[2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      kind_in = kind_ff;
      len_in = len_ff;
      if (wr_en) begin
         case (idx)
            afe_pkg::REG_FADE_KIND: kind_in = pwdata[2:0];
            afe_pkg::REG_FADE_LENGTH: len_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         afe_pkg::REG_FADE_KIND: prdata = {{(afe_pkg::DATA_W-3){1'b0}}, kind_ff};
         afe_pkg::REG_FADE_LENGTH: prdata = len_ff;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= afe_pkg::KIND_NONE;
         len_ff <= afe_pkg::LEN_DEFAULT_US;
      end else begin
         kind_ff <= kind_in;
         len_ff <= len_in;
      end
   end

   assign cfg_kind = kind_ff;
   assign cfg_len = len_ff;

endmodule

@@ rtl/afe_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module afe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  afe_pkg::afe_status_type status,
   output afe_pkg::afe_cmd_type    cmd
);

   afe_pkg::ctrl_state_type      state_ff, state_in;
   logic [afe_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         afe_pkg::ST_IDLE: begin
            if (req_valid) state_in = afe_pkg::ST_EXEC;
         end
         afe_pkg::ST_EXEC: begin
            state_in = status.tick_active ? afe_pkg::ST_NUMER : afe_pkg::ST_RESULT;
         end
         afe_pkg::ST_NUMER: state_in = afe_pkg::ST_SCALE;
         afe_pkg::ST_SCALE: state_in = afe_pkg::ST_DIVIDE;
         afe_pkg::ST_DIVIDE: begin
            if (cnt_ff == afe_pkg::DIV_LAST) state_in = afe_pkg::ST_RESULT;
         end
         afe_pkg::ST_RESULT: begin
            if (rsp_free) state_in = afe_pkg::ST_IDLE;
         end
         default: state_in = afe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         afe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch_req = req_valid;
         end
         afe_pkg::ST_EXEC: cmd.exec = 1'b1;
         afe_pkg::ST_NUMER: cmd.numer = 1'b1;
         afe_pkg::ST_SCALE: cmd.scale = 1'b1;
         afe_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         afe_pkg::ST_RESULT: cmd.commit = rsp_free;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = (state_ff == afe_pkg::ST_DIVIDE) ? cnt_ff + 1'b1 : '0;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afe_pkg::ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `AFE_ASSERT_NEXT(a_accept_to_exec, req_valid && req_ready, state_ff == afe_pkg::ST_EXEC)
   `AFE_ASSERT_NEXT(a_idle_tick_skips, state_ff == afe_pkg::ST_EXEC && !status.tick_active, state_ff == afe_pkg::ST_RESULT)
   `AFE_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_ff)

endmodule

@@ rtl/afe_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module afe_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  afe_pkg::afe_cmd_type       cmd,
   output afe_pkg::afe_status_type    status,
   input  logic                       req_mode,
   input  logic [afe_pkg::DT_W-1:0]   req_elapsed,
   input  logic [2:0]                 cfg_kind,
   input  logic [afe_pkg::LEN_W-1:0]  cfg_len,
   output logic [afe_pkg::QUO_W-1:0]  alpha,
   output logic                       fading,
   output logic                       finished
);

   // Envelope state.
   logic [afe_pkg::QUO_W-1:0]  opacity_ff, opacity_in;
   logic [afe_pkg::LEN_W-1:0]  elapsed_ff, elapsed_in;
   logic                       running_ff, running_in;
   afe_pkg::fade_kind_type     kind_ff, kind_in;
   logic [afe_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       fin_ff, fin_in;
   logic                       upd_ff, upd_in;

   // Per-request working registers.
   logic                       mode_ff, mode_in;
   logic [afe_pkg::DT_W-1:0]   dt_ff, dt_in;
   logic [afe_pkg::LEN_W-1:0]  t_ff, t_in;
   logic [afe_pkg::LEN_W-1:0]  num_ff, num_in;
   logic [afe_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [afe_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [afe_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [afe_pkg::QUO_W-1:0]  alpha_ff, alpha_in;
   logic                       fading_ff, fading_in;
   logic                       finished_ff, finished_in;

   logic                       active;
   logic [afe_pkg::LEN_W:0]    sum;
   logic [afe_pkg::LEN_W-1:0]  sat;
   afe_pkg::fade_kind_type     arm_kind;
   logic [afe_pkg::LEN_W:0]    t2;
   logic [afe_pkg::LEN_W:0]    len_ext;
   logic [afe_pkg::LEN_W-1:0]  d_minus_t;
   logic [afe_pkg::LEN_W:0]    lo_diff;
   logic [afe_pkg::LEN_W:0]    hi_diff;
   logic [afe_pkg::LEN_W:0]    back_twice;
   logic                       first_half;
   logic [afe_pkg::LEN_W-1:0]  num_calc;
   logic [afe_pkg::REM_W-1:0]  div_ext;
   logic                       ge;

   assign active = running_ff && (kind_ff != afe_pkg::KIND_NONE);
   assign status.tick_active = !mode_ff && active;

   assign sum = {1'b0, elapsed_ff} + {{(afe_pkg::LEN_W-afe_pkg::DT_W+1){1'b0}}, dt_ff};
   assign sat = sum[afe_pkg::LEN_W] ? '1 : sum[afe_pkg::LEN_W-1:0];

   assign arm_kind = (cfg_kind <= afe_pkg::KIND_OUT_IN) ?
                     afe_pkg::fade_kind_type'(cfg_kind) : afe_pkg::KIND_NONE;

   // Every branch of the envelope keeps its numerator within the fade length.
   assign t2 = {t_ff, 1'b0};
   assign len_ext = {1'b0, len_ff};
   assign first_half = t2 < len_ext;
   assign d_minus_t = len_ff - t_ff;
   assign back_twice = {d_minus_t, 1'b0};
   assign lo_diff = len_ext - t2;
   assign hi_diff = t2 - len_ext;

   always_comb begin
      case (kind_ff)
         afe_pkg::KIND_IN: num_calc = t_ff;
         afe_pkg::KIND_OUT: num_calc = d_minus_t;
         afe_pkg::KIND_IN_OUT: begin
            num_calc = first_half ? t2[afe_pkg::LEN_W-1:0] : back_twice[afe_pkg::LEN_W-1:0];
         end
         afe_pkg::KIND_OUT_IN: begin
            num_calc = first_half ? lo_diff[afe_pkg::LEN_W-1:0] : hi_diff[afe_pkg::LEN_W-1:0];
         end
         default: num_calc = '0;
      endcase
   end

   assign div_ext = {1'b0, div_ff};
   assign ge = rem_ff >= div_ext;

   always_comb begin
      opacity_in = opacity_ff;
      elapsed_in = elapsed_ff;
      running_in = running_ff;
      kind_in = kind_ff;
      len_in = len_ff;
      fin_in = fin_ff;
      upd_in = upd_ff;
      mode_in = mode_ff;
      dt_in = dt_ff;
      t_in = t_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      alpha_in = alpha_ff;
      fading_in = fading_ff;
      finished_in = finished_ff;

      if (cmd.latch_req) begin
         mode_in = req_mode;
         dt_in = req_elapsed;
      end

      if (cmd.exec) begin
         fin_in = 1'b0;
         upd_in = 1'b0;
         if (mode_ff) begin
            kind_in = arm_kind;
            len_in = (cfg_len > afe_pkg::LEN_MIN_US) ? cfg_len : afe_pkg::LEN_DEFAULT_US;
            elapsed_in = '0;
            running_in = 1'b1;
            if (arm_kind == afe_pkg::KIND_IN || arm_kind == afe_pkg::KIND_IN_OUT) begin
               opacity_in = afe_pkg::ALPHA_CLEAR;
            end else if (arm_kind == afe_pkg::KIND_OUT || arm_kind == afe_pkg::KIND_OUT_IN) begin
               opacity_in = afe_pkg::ALPHA_OPAQUE;
            end
         end else if (active) begin
            elapsed_in = sat;
            t_in = (sat < len_ff) ? sat : len_ff;
            fin_in = sat >= len_ff;
            upd_in = 1'b1;
         end
      end

      if (cmd.numer) begin
         num_in = num_calc;
      end

      if (cmd.scale) begin
         rem_in = {num_ff, {afe_pkg::QUO_W{1'b0}}} - {{afe_pkg::QUO_W{1'b0}}, num_ff};
         div_in = {len_ff, {(afe_pkg::QUO_W-1){1'b0}}};
         quo_in = '0;
      end

      if (cmd.div_step) begin
         if (ge) rem_in = rem_ff - div_ext;
         quo_in = {quo_ff[afe_pkg::QUO_W-2:0], ge};
         div_in = div_ff >> 1;
      end

      if (cmd.commit) begin
         if (upd_ff) opacity_in = quo_ff;
         if (fin_ff) begin
            running_in = 1'b0;
            kind_in = afe_pkg::KIND_NONE;
         end
         alpha_in = upd_ff ? quo_ff : opacity_ff;
         fading_in = !fin_ff && active;
         finished_in = fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= afe_pkg::ALPHA_OPAQUE;
         elapsed_ff <= '0;
         running_ff <= 1'b0;
         kind_ff <= afe_pkg::KIND_NONE;
         len_ff <= afe_pkg::LEN_DEFAULT_US;
         fin_ff <= 1'b0;
         upd_ff <= 1'b0;
      end else begin
         opacity_ff <= opacity_in;
         elapsed_ff <= elapsed_in;
         running_ff <= running_in;
         kind_ff <= kind_in;
         len_ff <= len_in;
         fin_ff <= fin_in;
         upd_ff <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      dt_ff <= dt_in;
      t_ff <= t_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      alpha_ff <= alpha_in;
      fading_ff <= fading_in;
      finished_ff <= finished_in;
   end

   assign alpha = alpha_ff;
   assign fading = fading_ff;
   assign finished = finished_ff;

   `AFE_ASSERT_SAME(a_rem_bounded, cmd.div_step, rem_ff < (div_ext << 1))
   `AFE_ASSERT_NEXT(a_finish_stops, cmd.commit && fin_ff, !running_ff && kind_ff == afe_pkg::KIND_NONE)
   `AFE_ASSERT_NEXT(a_timer_grows, cmd.exec && !mode_ff && active, elapsed_ff >= $past(elapsed_ff))

endmodule

@@ rtl/alpha_fade_envelope_core.sv @@
`timescale 1ns / 1ps
// Channel    Direction  Handshake              Payload
// req_chan   in         valid/ready            mode, elapsed_us
// rsp_chan   out        valid/ready            alpha, fading, finished
// APB        in         psel/penable, pready   paddr, pwdata, prdata
//
// A tick request on a running fade passes through the accumulate step, numerator selection,
// scaling, the shift-subtract divider that forms alpha and the write-back, after which its
// response is valid. A start request, or a tick with no fade running, skips to write-back.
// Once the response register is loaded the controller is idle and can take the next request.
// Reset is synchronous and active high; it restores full opacity with no fade armed.
// A response waiting on rsp_chan does not block the next request from being accepted;
// only the final write-back cycle waits for the response register to free up.
module alpha_fade_envelope_core (
   input  logic                        clock,
   input  logic                        reset,
   afe_req_if.sink                     req_chan,
   afe_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [afe_pkg::ADDR_W-1:0]  paddr,
   input  logic [afe_pkg::DATA_W-1:0]  pwdata,
   output logic [afe_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   // Configuration values as last written. They are sampled only when a start
   // request is processed, so a running fade keeps the kind and length it armed with.
   logic [2:0]                 cfg_kind;
   logic [afe_pkg::LEN_W-1:0]  cfg_len;

   // Command and status between the sequencer and the arithmetic.
   afe_pkg::afe_cmd_type       cmd;
   afe_pkg::afe_status_type    status;

   afe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg_kind (cfg_kind),
      .cfg_len  (cfg_len)
   );

   // The controller walks each request through arm or accumulate and the final write-back;
   // a running fade's tick adds numerator selection, scaling by 255 and eight divide steps.
   afe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the fade state, the saturating timer and the divider.
   // On a fade tick, alpha is the exact floor of 255 times the envelope numerator over length.
   afe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_mode    (req_chan.mode),
      .req_elapsed (req_chan.elapsed_us),
      .cfg_kind    (cfg_kind),
      .cfg_len     (cfg_len),
      .alpha       (rsp_chan.alpha),
      .fading      (rsp_chan.fading),
      .finished    (rsp_chan.finished)
   );

endmodule
